// ===== rtl/core/itrm_pkg.sv =====
// Shared types and constants for the interval timer read model.
// No dependencies; imported by every module under rtl/core.
package itrm_pkg;

  // Transaction codes on in_mode
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_REBASE = 2'd2;

  // Register addresses (low three bits)
  localparam logic [2:0] ADDR_TIMER_A = 3'd4;
  localparam logic [2:0] ADDR_FLAG_A  = 3'd5;
  localparam logic [2:0] ADDR_TIMER_B = 3'd6;
  localparam logic [2:0] ADDR_FLAG_B  = 3'd7;

  localparam logic [7:0] FLAG_BYTE   = 8'h80;
  localparam logic [7:0] RESET_COUNT = 8'd25;
  localparam logic [3:0] RESET_SHIFT = 4'd6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] access_cycle;
    logic [2:0]  reg_address;
    logic [7:0]  load_count;
    logic [3:0]  load_shift;
    logic [31:0] rebase_cycles;
  } item_t;

endpackage

// ===== rtl/core/itrm_in_stage.sv =====
// Input register stage: captures one transaction and holds it until the
// compute stage takes it. Depends on itrm_pkg.
module itrm_in_stage
  import itrm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  s1_valid,
  output item_t s1_item
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  accept;

  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (advance) begin
      s1_valid_nxt = accept;
    end else if (accept) begin
      // empty stage fills even while the output side is blocked
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ===== rtl/core/itrm_calc.sv =====
// Timer state and the single-pass read computation.
// Depends on itrm_pkg; state updates when a transaction leaves the input stage.
module itrm_calc
  import itrm_pkg::*;
#(
  parameter int CYCLE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  item_t      item,
  output logic [7:0] read_data
);

  localparam int CW = CYCLE_WIDTH;

  logic [CW-1:0] start_r;
  logic [CW-1:0] span_r;      // loaded count << shift, kept from the load
  logic [CW-1:0] offset_r;    // expiry read cycle - (start + span); rebase leaves it as is
  logic [7:0]    count_r;
  logic [3:0]    shift_r;
  logic          expired_r;

  logic [CW-1:0] now, delta, scaled, coarse, fine, new_offset, late_val;
  logic          coarse_neg, latch;

  assign now        = CW'(item.access_cycle);
  assign delta      = now - CW'(1) - start_r;
  assign scaled     = delta >> shift_r;
  assign coarse     = CW'(count_r) - scaled - CW'(1);
  assign coarse_neg = coarse[CW-1];
  assign fine       = span_r - delta - CW'(1);
  assign new_offset = now - start_r - span_r;
  assign late_val   = CW'(count_r) - scaled - (expired_r ? offset_r : new_offset);

  // First timer read at fine value -2 or below latches the expiry
  always_comb begin
    latch = 1'b0;
    if (item.mode == MODE_READ &&
        (item.reg_address == ADDR_TIMER_A || item.reg_address == ADDR_TIMER_B)) begin
      latch = coarse_neg && fine[CW-1] && (fine != {CW{1'b1}}) && !expired_r;
    end
  end

  always_comb begin
    read_data = 8'h00;
    if (item.mode == MODE_READ) begin
      case (item.reg_address) inside
        ADDR_TIMER_A, ADDR_TIMER_B: begin
          if (!coarse_neg) begin
            read_data = coarse[7:0];
          end else if (expired_r || latch) begin
            read_data = late_val[7:0];
          end else begin
            read_data = fine[7:0];
          end
        end
        ADDR_FLAG_A, ADDR_FLAG_B: begin
          read_data = (!coarse_neg || expired_r) ? 8'h00 : FLAG_BYTE;
        end
        default: read_data = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      span_r    <= CW'(RESET_COUNT) << RESET_SHIFT;
      offset_r  <= '0;
      count_r   <= RESET_COUNT;
      shift_r   <= RESET_SHIFT;
      expired_r <= 1'b0;
    end else if (fire) begin
      if (item.mode == MODE_LOAD) begin
        start_r   <= now;
        count_r   <= item.load_count;
        shift_r   <= item.load_shift;
        span_r    <= CW'(item.load_count) << item.load_shift;
        expired_r <= 1'b0;
      end else if (item.mode == MODE_REBASE) begin
        start_r <= start_r - CW'(item.rebase_cycles);
      end else if (latch) begin
        expired_r <= 1'b1;
        offset_r  <= new_offset;
      end
    end
  end

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_LOAD |=> !expired_r)
    else $error("expiry flag survived a load");

  a_rise_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(expired_r) |-> $past(fire && item.mode == MODE_READ))
    else $error("expiry flag set outside a read");

  a_no_latch_when_running: assert property (@(posedge clk) disable iff (!rst_n)
    latch |-> coarse_neg && !expired_r)
    else $error("expiry latched while timer running");

endmodule

// ===== rtl/core/interval_timer_read_model.sv =====
// Top level of the interval timer read model: input stage, timer compute
// stage and output register. Depends on itrm_pkg, itrm_in_stage, itrm_calc.
//
// Usage:
//   Input channel in_*: one transaction per item (load, register read or
//   rebase), accepted when in_valid is high and in_stall is low.
//   Output channel out_*: exactly one out_read_data per input transaction,
//   in order; loads, rebases and unused addresses return 0.
//   Data path: an accepted transaction is held in the input register, then
//   in the output register; out_valid rises when it reaches the output register.
//   Throughput: 1 transaction per cycle when out_stall is low; timer state is
//   read and updated by one pass of logic between input and output registers.
//   While out_stall holds, the output register keeps its result and the input
//   register can still take one more transaction; in_stall rises only when
//   both are full.
//   Reset (rst_n low, synchronous): pipeline emptied, timer set to count 25,
//   shift 6, start cycle 0, expiry flag cleared. No clearing pass.
//   Cycle arithmetic wraps at CYCLE_WIDTH bits.
module interval_timer_read_model
  import itrm_pkg::*;
#(
  parameter int CYCLE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_access_cycle,
  input  logic [2:0]  in_reg_address,
  input  logic [7:0]  in_load_count,
  input  logic [3:0]  in_load_shift,
  input  logic [31:0] in_rebase_cycles,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data
);

  item_t      in_item, s1_item;
  logic       s1_valid, advance, fire;
  logic [7:0] calc_data;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;

  assign in_item = '{mode: in_mode, access_cycle: in_access_cycle,
                     reg_address: in_reg_address, load_count: in_load_count,
                     load_shift: in_load_shift, rebase_cycles: in_rebase_cycles};

  assign advance = !out_valid_r || !out_stall;
  assign fire    = s1_valid && advance;

  itrm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  itrm_calc #(
    .CYCLE_WIDTH (CYCLE_WIDTH)
  ) u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (s1_item),
    .read_data (calc_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= calc_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid_r)
    else $error("input stalled with room in the pipeline");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted transaction lost");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && out_valid_r && out_stall |=> s1_valid && out_valid_r)
    else $error("transaction dropped while output stalled");

endmodule
